/* rtl/core/clns_pkg.sv */
package clns_pkg;

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int WAIT_W   = 22;
    localparam int US_W     = 16;
    localparam int SETTLE_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PHASE_W  = 3;
    localparam int IDX_W    = 2;

    // request codes
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSTR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DATA   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GLYPH  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH    = 3'd4;

    localparam logic [US_W-1:0]     RST_PULSE    = 16'd2000;
    localparam logic [US_W-1:0]     RST_BYTE_GAP = 16'd2000;
    localparam logic [US_W-1:0]     RST_POWER_UP = 16'd4000;
    localparam logic [SETTLE_W-1:0] RST_SETTLE   = 20'd200000;
    localparam logic [US_W-1:0]     RST_GLYPH    = 16'd1000;

    // bus states within one byte
    localparam logic [PHASE_W-1:0] PH_HI_SETUP = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HI_PULSE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LO_SETUP = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LO_PULSE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_GAP      = 3'd4;

    localparam logic [IDX_W-1:0] INIT_LAST_IDX = 2'd3;

    localparam logic [BYTE_W-1:0] SET_DDRAM   = 8'h80;
    localparam logic [BYTE_W-1:0] LINE2_BIT   = 8'h40;
    localparam logic [BYTE_W-1:0] CHAR_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_MIN    = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_MAX    = 8'h7F;
    localparam logic [BYTE_W-1:0] ROW_FIRST   = 8'd1;
    localparam logic [BYTE_W-1:0] ROW_SECOND  = 8'd2;

    // function set 4-bit 2-line, display on, entry mode, clear
    function automatic logic [BYTE_W-1:0] init_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = 8'h28;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h06;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

    typedef struct packed {
        logic               load;
        logic               emit;
        logic               power;
        logic               init;
        logic [PHASE_W-1:0] phase;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic emits;
        logic is_init;
    } t_dp_status;

endpackage

/* rtl/core/clns_req_if.sv */
interface clns_req_if;
    logic                            valid;
    logic                            ready;
    logic [clns_pkg::CMD_W-1:0]      cmd;
    logic [clns_pkg::BYTE_W-1:0]     value;
    logic [clns_pkg::BYTE_W-1:0]     row;
    logic                            end_of_run;

    modport source (output valid, cmd, value, row, end_of_run, input ready);
    modport sink   (input valid, cmd, value, row, end_of_run, output ready);
endinterface

/* rtl/core/clns_bus_if.sv */
interface clns_bus_if;
    logic                            valid;
    logic                            ready;
    logic                            reg_sel;
    logic                            enable;
    logic [clns_pkg::NIB_W-1:0]      nibble;
    logic [clns_pkg::WAIT_W-1:0]     wait_us;
    logic                            last;

    modport source (output valid, reg_sel, enable, nibble, wait_us, last, input ready);
    modport sink   (input valid, reg_sel, enable, nibble, wait_us, last, output ready);
endinterface

/* rtl/core/clns_ctrl.sv */
module clns_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  clns_pkg::t_dp_status i_status,
    output clns_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POWER = 2'd1;
    localparam logic [1:0] S_BYTE  = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [clns_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [clns_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                         r_init, n_init;
    logic                         byte_done;

    assign o_req_ready = (r_state == S_IDLE);
    assign byte_done   = (r_phase == clns_pkg::PH_GAP);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        n_init  = r_init;
        o_cmd       = '0;
        o_cmd.load  = 1'b0;
        o_cmd.init  = r_init;
        o_cmd.phase = r_phase;
        o_cmd.idx   = r_idx;
        o_cmd.last  = byte_done && (!r_init || r_idx == clns_pkg::INIT_LAST_IDX);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_req_valid;
                if (i_req_valid && i_status.emits) begin
                    n_init  = i_status.is_init;
                    n_phase = clns_pkg::PH_HI_SETUP;
                    n_idx   = '0;
                    n_state = i_status.is_init ? S_POWER : S_BYTE;
                end
            end
            S_POWER: begin
                o_cmd.power = 1'b1;
                o_cmd.last  = 1'b0;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_BYTE;
                end
            end
            S_BYTE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (byte_done) begin
                        n_phase = clns_pkg::PH_HI_SETUP;
                        if (o_cmd.last) begin
                            n_state = S_IDLE;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_phase = r_phase + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= clns_pkg::PH_HI_SETUP;
            r_idx   <= '0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_init  <= n_init;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= clns_pkg::PH_GAP)
        else $error("byte phase out of range");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_phase == clns_pkg::PH_HI_SETUP && r_idx == '0))
        else $error("idle with byte sequencing in flight");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("final beat did not return to idle");

    a_plain_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BYTE && !r_init) |-> (r_idx == '0))
        else $error("plain request sent more than one byte");

endmodule

/* rtl/core/clns_dpath.sv */
module clns_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [clns_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [clns_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [clns_pkg::CMD_W-1:0]          i_cmd,
    input  logic [clns_pkg::BYTE_W-1:0]         i_value,
    input  logic [clns_pkg::BYTE_W-1:0]         i_row,
    input  logic                                i_end_of_run,
    input  clns_pkg::t_dp_cmd                   i_ctl,
    output clns_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_reg_sel,
    output logic                                o_enable,
    output logic [clns_pkg::NIB_W-1:0]          o_nibble,
    output logic [clns_pkg::WAIT_W-1:0]         o_wait_us,
    output logic                                o_last
);

    logic [clns_pkg::US_W-1:0]     r_pulse, r_byte_gap, r_power_up, r_glyph_gap;
    logic [clns_pkg::SETTLE_W-1:0] r_settle;
    logic                          r_text_stopped, n_text_stopped;

    logic                          r_req_rs, n_req_rs;
    logic                          r_req_glyph, n_req_glyph;
    logic [clns_pkg::BYTE_W-1:0]   r_req_byte, n_req_byte;
    logic                          n_emits;
    logic [clns_pkg::BYTE_W-1:0]   col;

    logic                          r_out_valid;
    logic                          r_rs, r_en, r_last;
    logic [clns_pkg::NIB_W-1:0]    r_nib;
    logic [clns_pkg::WAIT_W-1:0]   r_wait;

    logic [clns_pkg::BYTE_W-1:0]   cur_byte;
    logic [clns_pkg::SETTLE_W-1:0] extra;
    logic                          b_rs, b_en;
    logic [clns_pkg::NIB_W-1:0]    b_nib;
    logic [clns_pkg::WAIT_W-1:0]   b_wait;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse     <= clns_pkg::RST_PULSE;
            r_byte_gap  <= clns_pkg::RST_BYTE_GAP;
            r_power_up  <= clns_pkg::RST_POWER_UP;
            r_settle    <= clns_pkg::RST_SETTLE;
            r_glyph_gap <= clns_pkg::RST_GLYPH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clns_pkg::CFG_PULSE:    r_pulse     <= i_cfg_data[clns_pkg::US_W-1:0];
                clns_pkg::CFG_BYTE_GAP: r_byte_gap  <= i_cfg_data[clns_pkg::US_W-1:0];
                clns_pkg::CFG_POWER_UP: r_power_up  <= i_cfg_data[clns_pkg::US_W-1:0];
                clns_pkg::CFG_SETTLE:   r_settle    <= i_cfg_data;
                clns_pkg::CFG_GLYPH:    r_glyph_gap <= i_cfg_data[clns_pkg::US_W-1:0];
                default: ;
            endcase
        end
    end

    // request decode
    assign col = i_value - 8'd1;

    always_comb begin
        n_req_rs       = 1'b0;
        n_req_glyph    = 1'b0;
        n_req_byte     = i_value;
        n_emits        = 1'b0;
        n_text_stopped = r_text_stopped;
        case (i_cmd)
            clns_pkg::CMD_INIT:  n_emits = 1'b1;
            clns_pkg::CMD_INSTR: n_emits = 1'b1;
            clns_pkg::CMD_DATA: begin
                n_emits  = 1'b1;
                n_req_rs = 1'b1;
            end
            clns_pkg::CMD_TEXT: begin
                n_req_rs = 1'b1;
                n_emits  = !r_text_stopped
                           && (i_value inside {[clns_pkg::CHAR_MIN:clns_pkg::CHAR_MAX]});
                // a newline mutes the rest of the run
                if (!r_text_stopped && i_value == clns_pkg::CHAR_NL) begin
                    n_text_stopped = 1'b1;
                end
                if (i_end_of_run) begin
                    n_text_stopped = 1'b0;
                end
            end
            clns_pkg::CMD_LOCATE: begin
                n_emits    = i_row inside {clns_pkg::ROW_FIRST, clns_pkg::ROW_SECOND};
                n_req_byte = col | clns_pkg::SET_DDRAM
                             | ((i_row == clns_pkg::ROW_SECOND) ? clns_pkg::LINE2_BIT : 8'h00);
            end
            clns_pkg::CMD_GLYPH: begin
                n_emits     = 1'b1;
                n_req_rs    = 1'b1;
                n_req_glyph = 1'b1;
            end
            default: n_emits = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_stopped <= 1'b0;
        end else if (i_ctl.load) begin
            r_text_stopped <= n_text_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req_rs    <= n_req_rs;
            r_req_glyph <= n_req_glyph;
            r_req_byte  <= n_req_byte;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.emits    = n_emits;
    assign o_status.is_init  = (i_cmd == clns_pkg::CMD_INIT);

    // bus state for the current beat
    always_comb begin
        cur_byte = i_ctl.init ? clns_pkg::init_byte(i_ctl.idx) : r_req_byte;
        if (i_ctl.init) begin
            extra = (i_ctl.idx == clns_pkg::INIT_LAST_IDX) ? r_settle : '0;
        end else begin
            extra = r_req_glyph ? {4'd0, r_glyph_gap} : '0;
        end
        b_rs   = i_ctl.init ? 1'b0 : r_req_rs;
        b_en   = 1'b0;
        b_nib  = cur_byte[3:0];
        b_wait = '0;
        if (i_ctl.power) begin
            b_rs   = 1'b0;
            b_en   = 1'b1;
            b_nib  = '0;
            b_wait = {5'd0, r_power_up, 1'b0};
        end else begin
            case (i_ctl.phase)
                clns_pkg::PH_HI_SETUP: begin
                    // enable is still high from the power-up beat
                    b_en  = i_ctl.init && (i_ctl.idx == '0);
                    b_nib = cur_byte[7:4];
                end
                clns_pkg::PH_HI_PULSE: begin
                    b_en   = 1'b1;
                    b_nib  = cur_byte[7:4];
                    b_wait = {6'd0, r_pulse};
                end
                clns_pkg::PH_LO_SETUP: b_en = 1'b0;
                clns_pkg::PH_LO_PULSE: begin
                    b_en   = 1'b1;
                    b_wait = {6'd0, r_pulse};
                end
                clns_pkg::PH_GAP: b_wait = {6'd0, r_byte_gap} + {2'd0, extra};
                default: b_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_rs   <= b_rs;
            r_en   <= b_en;
            r_nib  <= b_nib;
            r_wait <= b_wait;
            r_last <= i_ctl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_reg_sel   = r_rs;
    assign o_enable    = r_en;
    assign o_nibble    = r_nib;
    assign o_wait_us   = r_wait;
    assign o_last      = r_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit |-> (!r_out_valid || i_out_ready))
        else $error("beat overwritten before it was taken");

    a_emit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit |=> r_out_valid)
        else $error("emitted beat not presented");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> !i_ctl.emit)
        else $error("request loaded while a beat is being built");

endmodule

/* rtl/core/char_lcd_nibble_bus_sequencer_core.sv */
// 4-bit character lcd bus sequencer. each request is turned into a series of bus beats
// (register select, enable level, d7..d4, hold time in us, last flag); a byte is sent high
// nibble first as five beats, power-up init as twenty-one, and text chars outside
// 0x20..0x7f, text after a newline in the same run, locate to a row other than 1 or 2 and
// request codes 6 and 7 produce no beat at all. the request port takes one request in a
// cycle, and a request that makes beats then keeps it busy while the controller steps
// through them, one beat per cycle when the bus side is ready. the last beat sits in an
// output register, so the next request can be taken while it waits. configuration writes
// (index 0 pulse, 1 byte gap, 2 power-up, 3 settle, 4 glyph gap) are taken at any time but
// should only be issued while no request is in flight.
module char_lcd_nibble_bus_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clns_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [clns_pkg::CFG_DATA_W-1:0] i_cfg_data,
    clns_req_if.sink                        i_req,
    clns_bus_if.source                      o_bus
);

    clns_pkg::t_dp_cmd    ctl;
    clns_pkg::t_dp_status status;
    logic                 req_ready;

    assign i_req.ready = req_ready;

    clns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (ctl)
    );

    clns_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_req.cmd),
        .i_value      (i_req.value),
        .i_row        (i_req.row),
        .i_end_of_run (i_req.end_of_run),
        .i_ctl        (ctl),
        .o_status     (status),
        .i_out_ready  (o_bus.ready),
        .o_out_valid  (o_bus.valid),
        .o_reg_sel    (o_bus.reg_sel),
        .o_enable     (o_bus.enable),
        .o_nibble     (o_bus.nibble),
        .o_wait_us    (o_bus.wait_us),
        .o_last       (o_bus.last)
    );

endmodule

/* verif/char_lcd_nibble_bus_sequencer_core_test.sv */
module char_lcd_nibble_bus_sequencer_core_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_PCT = 19;

    // request codes the block must ignore
    localparam logic [clns_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [clns_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    // a register index with no register behind it
    localparam logic [clns_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    localparam logic [clns_pkg::BYTE_W-1:0] INIT_FUNC_SET = 8'h28;
    localparam logic [clns_pkg::BYTE_W-1:0] INIT_DISP_ON  = 8'h0C;
    localparam logic [clns_pkg::BYTE_W-1:0] INIT_ENTRY    = 8'h06;
    localparam logic [clns_pkg::BYTE_W-1:0] INIT_CLEAR    = 8'h01;

    typedef struct packed {
        logic                        reg_sel;
        logic                        enable;
        logic [clns_pkg::NIB_W-1:0]  nibble;
        logic [clns_pkg::WAIT_W-1:0] wait_us;
        logic                        last;
    } t_bus_beat;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [clns_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [clns_pkg::CFG_DATA_W-1:0] i_cfg_data;

    clns_req_if req_if ();
    clns_bus_if bus_if ();

    char_lcd_nibble_bus_sequencer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_bus      (bus_if)
    );

    // shadow of the block's registers and text state
    logic [clns_pkg::US_W-1:0]     cfg_pulse     = clns_pkg::RST_PULSE;
    logic [clns_pkg::US_W-1:0]     cfg_byte_gap  = clns_pkg::RST_BYTE_GAP;
    logic [clns_pkg::US_W-1:0]     cfg_power_up  = clns_pkg::RST_POWER_UP;
    logic [clns_pkg::SETTLE_W-1:0] cfg_settle    = clns_pkg::RST_SETTLE;
    logic [clns_pkg::US_W-1:0]     cfg_glyph_gap = clns_pkg::RST_GLYPH;
    logic                          text_halted   = 1'b0;

    t_bus_beat expected_beats[$];
    int        err_cnt   = 0;
    int        cycle_cnt = 0;
    logic      src_stalls  = 1'b1;
    logic      sink_stalls = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("char_lcd_nibble_bus_sequencer_core_test: errors");
            $finish;
        end
    end

    function automatic void push_beat(input logic rs, input logic en,
                                      input logic [clns_pkg::NIB_W-1:0] nib,
                                      input logic [clns_pkg::WAIT_W-1:0] hold);
        t_bus_beat b;
        b.reg_sel = rs;
        b.enable  = en;
        b.nibble  = nib;
        b.wait_us = hold;
        b.last    = 1'b0;
        expected_beats.push_back(b);
    endfunction

    // five beats per byte, high nibble first
    function automatic void push_byte(input logic rs, input logic [clns_pkg::BYTE_W-1:0] b,
                                      input logic [clns_pkg::WAIT_W-1:0] extra,
                                      input logic en_held);
        logic [clns_pkg::WAIT_W-1:0] pulse;
        pulse = {6'd0, cfg_pulse};
        push_beat(rs, en_held, b[7:4], '0);
        push_beat(rs, 1'b1, b[7:4], pulse);
        push_beat(rs, 1'b0, b[3:0], '0);
        push_beat(rs, 1'b1, b[3:0], pulse);
        push_beat(rs, 1'b0, b[3:0], {6'd0, cfg_byte_gap} + extra);
    endfunction

    function automatic void predict_bus_beats(input logic [clns_pkg::CMD_W-1:0] cmd,
                                              input logic [clns_pkg::BYTE_W-1:0] value,
                                              input logic [clns_pkg::BYTE_W-1:0] row,
                                              input logic eor);
        int                          n0;
        logic [clns_pkg::BYTE_W-1:0] col;
        n0  = expected_beats.size();
        col = value - 8'd1;
        case (cmd)
            clns_pkg::CMD_INIT: begin
                push_beat(1'b0, 1'b1, '0, {5'd0, cfg_power_up, 1'b0});
                // enable is still high from the power-up beat
                push_byte(1'b0, INIT_FUNC_SET, '0, 1'b1);
                push_byte(1'b0, INIT_DISP_ON, '0, 1'b0);
                push_byte(1'b0, INIT_ENTRY, '0, 1'b0);
                push_byte(1'b0, INIT_CLEAR, {2'd0, cfg_settle}, 1'b0);
            end
            clns_pkg::CMD_INSTR: push_byte(1'b0, value, '0, 1'b0);
            clns_pkg::CMD_DATA:  push_byte(1'b1, value, '0, 1'b0);
            clns_pkg::CMD_TEXT: begin
                if (!text_halted) begin
                    if (value == clns_pkg::CHAR_NL) begin
                        text_halted = 1'b1;
                    end else if (value inside {[clns_pkg::CHAR_MIN:clns_pkg::CHAR_MAX]}) begin
                        push_byte(1'b1, value, '0, 1'b0);
                    end
                end
                if (eor) begin
                    text_halted = 1'b0;
                end
            end
            clns_pkg::CMD_LOCATE: begin
                if (row == clns_pkg::ROW_FIRST) begin
                    push_byte(1'b0, col | clns_pkg::SET_DDRAM, '0, 1'b0);
                end else if (row == clns_pkg::ROW_SECOND) begin
                    push_byte(1'b0, col | clns_pkg::SET_DDRAM | clns_pkg::LINE2_BIT, '0, 1'b0);
                end
            end
            clns_pkg::CMD_GLYPH: push_byte(1'b1, value, {6'd0, cfg_glyph_gap}, 1'b0);
            default: ;
        endcase
        if (expected_beats.size() > n0) begin
            expected_beats[expected_beats.size()-1].last = 1'b1;
        end
    endfunction

    // bus side ready, stalls at random while sink_stalls is set
    always @(negedge i_clk) begin
        if (sink_stalls) begin
            bus_if.ready <= ($urandom_range(0, 99) >= STALL_PCT);
        end else begin
            bus_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_bus_beat got;
        t_bus_beat want;
        if (i_rst_n && bus_if.valid && bus_if.ready) begin
            got.reg_sel = bus_if.reg_sel;
            got.enable  = bus_if.enable;
            got.nibble  = bus_if.nibble;
            got.wait_us = bus_if.wait_us;
            got.last    = bus_if.last;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat rs=%0b en=%0b nib=%h wait=%0d last=%0b",
                         $time, got.reg_sel, got.enable, got.nibble, got.wait_us, got.last);
                err_cnt++;
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    $display("%0t: beat mismatch expected rs=%0b en=%0b nib=%h wait=%0d last=%0b",
                             $time, want.reg_sel, want.enable, want.nibble, want.wait_us,
                             want.last);
                    $display("%0t:                 actual rs=%0b en=%0b nib=%h wait=%0d last=%0b",
                             $time, got.reg_sel, got.enable, got.nibble, got.wait_us, got.last);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_req(input logic [clns_pkg::CMD_W-1:0] cmd,
                            input logic [clns_pkg::BYTE_W-1:0] value,
                            input logic [clns_pkg::BYTE_W-1:0] row, input logic eor);
        @(negedge i_clk);
        while (src_stalls && $urandom_range(0, 99) < STALL_PCT) begin
            req_if.valid      <= 1'b0;
            req_if.cmd        <= 3'($urandom);
            req_if.value      <= 8'($urandom);
            req_if.row        <= 8'($urandom);
            req_if.end_of_run <= 1'($urandom);
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.value      <= value;
        req_if.row        <= row;
        req_if.end_of_run <= eor;
        do @(posedge i_clk); while (!req_if.ready);
        predict_bus_beats(cmd, value, row, eor);
    endtask

    // let every expected beat drain, then give a request with no beats time to finish
    task automatic settle_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [clns_pkg::CFG_IDX_W-1:0] idx,
                             input logic [clns_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            clns_pkg::CFG_PULSE:    cfg_pulse     = data[clns_pkg::US_W-1:0];
            clns_pkg::CFG_BYTE_GAP: cfg_byte_gap  = data[clns_pkg::US_W-1:0];
            clns_pkg::CFG_POWER_UP: cfg_power_up  = data[clns_pkg::US_W-1:0];
            clns_pkg::CFG_SETTLE:   cfg_settle    = data;
            clns_pkg::CFG_GLYPH:    cfg_glyph_gap = data[clns_pkg::US_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [clns_pkg::CFG_DATA_W-1:0] pulse,
                                  input logic [clns_pkg::CFG_DATA_W-1:0] gap,
                                  input logic [clns_pkg::CFG_DATA_W-1:0] power,
                                  input logic [clns_pkg::CFG_DATA_W-1:0] settle,
                                  input logic [clns_pkg::CFG_DATA_W-1:0] glyph);
        write_reg(clns_pkg::CFG_PULSE, pulse);
        write_reg(clns_pkg::CFG_BYTE_GAP, gap);
        write_reg(clns_pkg::CFG_POWER_UP, power);
        write_reg(clns_pkg::CFG_SETTLE, settle);
        write_reg(clns_pkg::CFG_GLYPH, glyph);
    endtask

    function automatic logic [clns_pkg::CFG_DATA_W-1:0] pick_reg_value();
        logic [clns_pkg::CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = '1;
            2:       v = 20'($urandom_range(1, 8));
            default: v = 20'($urandom);
        endcase
        return v;
    endfunction

    task automatic test_reset_values();
        send_req(clns_pkg::CMD_INIT, 8'h00, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_INSTR, 8'h00, 8'hFF, 1'b1);
        send_req(clns_pkg::CMD_DATA, 8'hFF, 8'h00, 1'b0);
    endtask

    task automatic test_commands();
        send_req(clns_pkg::CMD_INSTR, 8'hFF, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_DATA, 8'h00, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_GLYPH, 8'hA5, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_GLYPH, 8'h5A, 8'hFF, 1'b1);
        // column zero wraps to 0xff before the address bits
        send_req(clns_pkg::CMD_LOCATE, 8'h00, clns_pkg::ROW_FIRST, 1'b0);
        send_req(clns_pkg::CMD_LOCATE, 8'h01, clns_pkg::ROW_FIRST, 1'b0);
        send_req(clns_pkg::CMD_LOCATE, 8'hFF, clns_pkg::ROW_SECOND, 1'b1);
        send_req(clns_pkg::CMD_LOCATE, 8'h05, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_LOCATE, 8'h05, 8'h03, 1'b0);
        send_req(clns_pkg::CMD_LOCATE, 8'h05, 8'hFF, 1'b0);
        send_req(CMD_SPARE_LO, 8'hFF, 8'hFF, 1'b1);
        send_req(CMD_SPARE_HI, 8'h41, clns_pkg::ROW_FIRST, 1'b0);
    endtask

    task automatic test_text_filter();
        send_req(clns_pkg::CMD_TEXT, 8'h1F, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_TEXT, clns_pkg::CHAR_MIN, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_TEXT, clns_pkg::CHAR_MAX, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_TEXT, 8'h80, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_TEXT, 8'hFF, 8'h00, 1'b0);
        // newline mutes the rest of the run, other commands still go out
        send_req(clns_pkg::CMD_TEXT, clns_pkg::CHAR_NL, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_TEXT, 8'h42, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_INSTR, 8'h33, 8'h00, 1'b1);
        send_req(clns_pkg::CMD_TEXT, 8'h43, 8'h00, 1'b1);
        send_req(clns_pkg::CMD_TEXT, 8'h44, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_TEXT, clns_pkg::CHAR_NL, 8'h00, 1'b1);
        send_req(clns_pkg::CMD_TEXT, 8'h45, 8'h00, 1'b1);
    endtask

    task automatic test_reg_extremes();
        settle_idle();
        write_all_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_req(clns_pkg::CMD_INIT, 8'h00, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_GLYPH, 8'hFF, 8'h00, 1'b1);
        settle_idle();
        write_all_regs('0, '0, '0, '0, '0);
        write_reg(CFG_NONE, 20'hFFFFF);
        send_req(clns_pkg::CMD_INIT, 8'h00, 8'h00, 1'b0);
        send_req(clns_pkg::CMD_GLYPH, 8'h00, 8'h00, 1'b1);
        send_req(clns_pkg::CMD_DATA, 8'h96, 8'h00, 1'b0);
    endtask

    task automatic send_random_seq(inout int sent);
        int                          n;
        logic [clns_pkg::BYTE_W-1:0] ch;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(0, 9))
                        0:       ch = clns_pkg::CHAR_NL;
                        1:       ch = 8'($urandom);
                        default: ch = 8'($urandom_range(clns_pkg::CHAR_MIN, clns_pkg::CHAR_MAX));
                    endcase
                    send_req(clns_pkg::CMD_TEXT, ch, 8'($urandom),
                             (k == n - 1) || ($urandom_range(0, 9) == 0));
                end
                sent += n;
            end
            4, 5: begin
                for (int k = 0; k < 8; k++) begin
                    send_req(clns_pkg::CMD_GLYPH, 8'($urandom), 8'($urandom), k == 7);
                end
                sent += 8;
            end
            6: begin
                send_req(clns_pkg::CMD_LOCATE, 8'($urandom),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2)),
                         1'($urandom));
                sent++;
            end
            7: begin
                send_req($urandom_range(0, 1) ? clns_pkg::CMD_INSTR : clns_pkg::CMD_DATA,
                         8'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end
            8: begin
                send_req(($urandom_range(0, 3) == 0) ? clns_pkg::CMD_INIT : clns_pkg::CMD_DATA,
                         8'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end
            default: begin
                send_req(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end
        endcase
    endtask

    task automatic test_random_traffic();
        int sent;
        for (int ph = 0; ph < 4; ph++) begin
            settle_idle();
            write_all_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                           pick_reg_value(), pick_reg_value());
            // one phase runs back to back on both sides
            src_stalls  = (ph != 2);
            sink_stalls = (ph != 2);
            sent = 0;
            while (sent < 22) send_random_seq(sent);
        end
        src_stalls  = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = '0;
        req_if.value      = '0;
        req_if.row        = '0;
        req_if.end_of_run = 1'b0;
        bus_if.ready      = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_commands();
        test_text_filter();
        test_reg_extremes();
        test_random_traffic();
        settle_idle();

        if (err_cnt == 0) begin
            $display("char_lcd_nibble_bus_sequencer_core_test: clean");
        end else begin
            $display("char_lcd_nibble_bus_sequencer_core_test: errors");
        end
        $finish;
    end

endmodule
